// ----- sv/sql_identifier_validator_core_macros.svh -----
// ----------------------------------------------------------------------------
// sql_identifier_validator_core_macros.svh
// Assertion shorthands for the identifier checker.
// ----------------------------------------------------------------------------
`ifndef SQL_IDENTIFIER_VALIDATOR_CORE_MACROS_SVH
`define SQL_IDENTIFIER_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, reset masked.
`define SQLID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define SQLID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sqlid_pkg.sv -----
// ----------------------------------------------------------------------------
// sqlid_pkg
// Shared types, character constants and class helpers for the identifier check.
// ----------------------------------------------------------------------------
package sqlid_pkg;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;

    // check_mode codes
    localparam logic MODE_QUALIFIED = 1'b0;
    localparam logic MODE_SIMPLE    = 1'b1;

    typedef enum logic [2:0] {
        ST_START = 3'd0,  // expecting start of name / part
        ST_WORD  = 3'd1,  // inside unquoted run
        ST_INQ   = 3'd2,  // inside quotes
        ST_QEND  = 3'd3,  // just saw a quote inside quotes
        ST_AFTER = 3'd4,  // trailing whitespace after a part
        ST_NEED  = 3'd5,  // after a dot, part required
        ST_FAIL  = 3'd6   // sticky reject
    } parse_state_t;

    // One parse step as seen by the top level
    typedef struct packed {
        parse_state_t next_state;
        logic         pass;       // name would pass if it ended here
    } step_res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) ||
               (c == CH_UNDERSCORE);
    endfunction

endpackage

// ----- sv/sqlid_step.sv -----
// ----------------------------------------------------------------------------
// sqlid_step
// Next-state and end-of-name decision for one byte in either check mode.
// ----------------------------------------------------------------------------
module sqlid_step (
    input  sqlid_pkg::parse_state_t state,
    input  logic [7:0]              ch,
    input  logic                    empty_string,
    input  logic                    mode,
    output sqlid_pkg::step_res_t    res
);
    import sqlid_pkg::*;

    parse_state_t nq;
    parse_state_t ns;
    parse_state_t nxt;

    // qualified dotted name
    always_comb
    begin
        nq = ST_FAIL;
        if (ch != CH_NUL)
        begin
            unique case (state)
                ST_START, ST_NEED:
                begin
                    if (is_ws(ch))           nq = state;
                    else if (ch == CH_QUOTE) nq = ST_INQ;
                    else if (is_word(ch))    nq = ST_WORD;
                    else                     nq = ST_FAIL;
                end
                ST_WORD:
                begin
                    if (is_word(ch))         nq = ST_WORD;
                    else if (ch == CH_DOT)   nq = ST_NEED;
                    else if (is_ws(ch))      nq = ST_AFTER;
                    else                     nq = ST_FAIL;
                end
                ST_INQ:
                    nq = (ch == CH_QUOTE) ? ST_QEND : ST_INQ;
                ST_QEND:
                begin
                    if (ch == CH_QUOTE)      nq = ST_INQ;
                    else if (ch == CH_DOT)   nq = ST_NEED;
                    else if (is_ws(ch))      nq = ST_AFTER;
                    else                     nq = ST_FAIL;
                end
                ST_AFTER:
                begin
                    if (is_ws(ch))           nq = ST_AFTER;
                    else if (ch == CH_DOT)   nq = ST_NEED;
                    else                     nq = ST_FAIL;
                end
                default:
                    nq = ST_FAIL;
            endcase
        end
    end

    // simple single name; NUL is an ordinary byte here
    always_comb
    begin
        unique case (state)
            ST_START:
            begin
                if (ch == CH_QUOTE)   ns = ST_INQ;
                else if (is_word(ch)) ns = ST_WORD;
                else                  ns = ST_FAIL;
            end
            ST_WORD: ns = is_word(ch) ? ST_WORD : ST_FAIL;
            ST_INQ:  ns = (ch == CH_QUOTE) ? ST_QEND : ST_INQ;
            ST_QEND: ns = (ch == CH_QUOTE) ? ST_INQ : ST_FAIL;
            default: ns = ST_FAIL;
        endcase
    end

    always_comb
    begin
        if (empty_string)             nxt = ST_FAIL;
        else if (mode == MODE_SIMPLE) nxt = ns;
        else                          nxt = nq;

        res.next_state = nxt;
        if (mode == MODE_SIMPLE)
            res.pass = (nxt == ST_WORD) || (nxt == ST_QEND);
        else
            res.pass = (nxt == ST_START) || (nxt == ST_WORD) ||
                       (nxt == ST_QEND)  || (nxt == ST_AFTER);
    end

endmodule

// ----- sv/sql_identifier_validator_core.sv -----
// Path: a last byte goes from the stage 1 register into the result register.
// Throughput: one byte per cycle; the parse step is a single state transition.
// The input stalls only when a last byte waits behind an unaccepted result.
// Reset (rst_n low, asynchronous): mode = qualified, parser at start of name,
// both pipeline stages empty.
// ----------------------------------------------------------------------------
// sql_identifier_validator_core
// Byte-serial SQL identifier syntax check with a one-bit result per name.
// ----------------------------------------------------------------------------
module sql_identifier_validator_core (
    input  logic       clk,
    input  logic       rst_n,

    // mode register write port
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,

    // byte input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       last,
    input  logic       empty_string,

    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       valid_res
);
    import sqlid_pkg::*;

    // config
    logic         mode_reg;

    // stage 1: registered input item
    logic         s1_valid_reg;
    logic [7:0]   s1_ch_reg;
    logic         s1_last_reg;
    logic         s1_empty_reg;

    // parser state carried from byte to byte
    parse_state_t state_reg;
    parse_state_t state_next;

    // stage 2: result register
    logic         res_valid_reg;
    logic         res_reg;

    step_res_t    step;
    logic         s1_adv;     // stage 1 item consumed this cycle
    logic         in_acc;
    logic         out_acc;

    sqlid_step u_step (
        .state        (state_reg),
        .ch           (s1_ch_reg),
        .empty_string (s1_empty_reg),
        .mode         (mode_reg),
        .res          (step)
    );

    // A non-last byte always moves on; a last byte needs room in the
    // result register (empty, or being drained this cycle).
    assign s1_adv   = s1_valid_reg &&
                      !(s1_last_reg && res_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = res_valid_reg && !out_stall;

    // Parser state: a mode write restarts the name, a last byte ends it.
    always_comb
    begin
        priority if (cfg_wr_en)
            state_next = ST_START;
        else if (s1_adv)
            state_next = s1_last_reg ? ST_START : step.next_state;
        else
            state_next = state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_QUALIFIED;
            state_reg     <= ST_START;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            state_reg <= state_next;

            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv && s1_last_reg)
                res_valid_reg <= 1'b1;
            else if (out_acc)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ch_reg    <= ch;
            s1_last_reg  <= last;
            s1_empty_reg <= empty_string;
        end
        if (s1_adv && s1_last_reg)
            res_reg <= step.pass;
    end

    assign out_valid = res_valid_reg;
    assign valid_res = res_reg;

endmodule

// ----- sv/sqlid_checker.sv -----
// ----------------------------------------------------------------------------
// sqlid_checker
// Port-level checks for the identifier validator, bound to the top level.
// ----------------------------------------------------------------------------
`include "sql_identifier_validator_core_macros.svh"

module sqlid_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_wr_en,
    input logic       cfg_wr_data,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] ch,
    input logic       last,
    input logic       empty_string,
    input logic       out_valid,
    input logic       out_stall,
    input logic       valid_res
);
    import sqlid_pkg::*;

    // result held while the sink stalls
    `SQLID_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(valid_res), "result dropped or changed under stall")

    // with the result register empty the input never backs up
    `SQLID_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall, "input stalled with empty output")

    // empty name finishing into a free output is registered as a reject
    `SQLID_ASSERT_NEXT(a_empty_rejects, (in_valid && !in_stall && last && empty_string) ##1 !out_valid, out_valid && !valid_res, "empty name not rejected")

    // a byte that does not end the name never produces a result
    `SQLID_ASSERT_NEXT(a_no_result_mid_name, (in_valid && !in_stall && !last) ##1 !out_valid, !out_valid, "result for an unfinished name")

endmodule

bind sql_identifier_validator_core sqlid_checker u_sqlid_checker (.*);
